[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/lmem_pkg.sv]
//------------------------------------------------------------------------------
// lmem_pkg
// Shared types and constants of the list-mode projection unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lmem_pkg;

  localparam int unsigned NumVoxelsDefault   = 262144;
  localparam int unsigned MaxElementsDefault = 256;

  localparam int unsigned IdxW   = 18;
  localparam int unsigned ValW   = 32;
  localparam int unsigned LenW   = 24;
  localparam int unsigned AccW   = 48;

  // Operation codes of an input item.
  localparam logic [1:0] OpLoadCur  = 2'd0;
  localparam logic [1:0] OpWriteNext = 2'd1;
  localparam logic [1:0] OpElement  = 2'd2;
  localparam logic [1:0] OpReadNext = 2'd3;

  // Result kinds.
  localparam logic KindIntegral = 1'b0;
  localparam logic KindReadback = 1'b1;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]      op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] value;
    logic [LenW-1:0] len;
    logic            last;
    logic            in_range;
  } item_t;

endpackage
`default_nettype wire

[rtl/core/lmem_ram.sv]
//------------------------------------------------------------------------------
// lmem_ram
// Generic single-port RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lmem_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle: an optional write plus a registered read of the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[rtl/core/lmem_recip.sv]
//------------------------------------------------------------------------------
// lmem_recip
// Restoring divider forming floor(2^48 / divisor), one quotient bit a cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lmem_recip (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lmem_pkg::AccW-1:0] divisor_i,
  output logic                           done_o,
  output logic      [lmem_pkg::AccW-1:0] recip_o
);

  localparam int unsigned W = lmem_pkg::AccW;

  logic          busy_q, busy_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [W:0]    rem_q, rem_d;
  logic [W:0]    quo_q, quo_d;
  logic [W-1:0]  div_q, div_d;
  logic [W+1:0]  trial;
  logic          done_q, done_d;

  // The dividend is 2^48: a single one then 48 zero bits, 49 steps in all.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'(W);
      rem_d  = '0;
      quo_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      trial = {rem_q, (cnt_q == 7'(W))} - {2'b00, div_q};
      if (!trial[W+1]) begin
        rem_d = trial[W:0];
        quo_d = {quo_q[W-1:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-1:0], (cnt_q == 7'(W))};
        quo_d = {quo_q[W-1:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  // Quotient saturates at 2^48-1 (divisor of one).
  assign done_o  = done_q;
  assign recip_o = quo_q[W] ? {W{1'b1}} : quo_q[W-1:0];

endmodule
`default_nettype wire

[rtl/core/lmem_front.sv]
//------------------------------------------------------------------------------
// lmem_front
// Accepts items, checks the voxel range and queues them for the back part.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lmem_front #(
  parameter int unsigned NumVoxels = lmem_pkg::NumVoxelsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [lmem_pkg::IdxW-1:0]      voxel_index_i,
  input  wire logic [lmem_pkg::ValW-1:0]      voxel_value_i,
  input  wire logic [lmem_pkg::LenW-1:0]      path_length_i,
  input  wire logic                           last_element_i,
  output logic                                busy_o,
  output logic                                q_valid_o,
  output lmem_pkg::item_t                     q_item_o,
  input  wire logic                           q_pop_i
);

  // Two-entry queue.
  lmem_pkg::item_t  ent_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push;
  lmem_pkg::item_t  item;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  // Classify the item: indexes beyond the image are flagged here.
  always_comb begin
    item.op       = operation_i;
    item.idx      = voxel_index_i;
    item.value    = voxel_value_i;
    item.len      = path_length_i;
    item.last     = last_element_i;
    item.in_range = (25'(voxel_index_i) < 25'(NumVoxels));
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = ent_q[rp_q];

  `ASSERT_CLK(a_no_pop_empty, q_pop_i |-> q_valid_o, "pop from empty queue")
  `ASSERT_CLK(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `ASSERT_CLK(a_cnt_track, (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1,
              "queue count lost a push")

endmodule
`default_nettype wire

[rtl/core/lmem_back.sv]
//------------------------------------------------------------------------------
// lmem_back
// Executes queued items: memory access, line integral and back projection.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lmem_back #(
  parameter int unsigned NumVoxels   = lmem_pkg::NumVoxelsDefault,
  parameter int unsigned MaxElements = lmem_pkg::MaxElementsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  lmem_pkg::item_t                     q_item_i,
  output logic                                q_pop_o,
  output logic                                result_valid_o,
  output logic                                result_kind_o,
  output logic      [lmem_pkg::AccW-1:0]      result_value_o,
  output logic                                integral_positive_o,
  output logic                                element_overflow_o
);

  localparam int unsigned VAw = $clog2(NumVoxels);
  localparam int unsigned EAw = $clog2(MaxElements);
  localparam int unsigned CntW = EAw + 1;
  localparam int unsigned IdxW = lmem_pkg::IdxW;
  localparam int unsigned ValW = lmem_pkg::ValW;
  localparam int unsigned LenW = lmem_pkg::LenW;
  localparam int unsigned AccW = lmem_pkg::AccW;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SElRd   = 4'd1;
  localparam logic [3:0] SElMul  = 4'd2;
  localparam logic [3:0] SElAcc  = 4'd3;
  localparam logic [3:0] SRbRd   = 4'd4;
  localparam logic [3:0] SRbOut  = 4'd5;
  localparam logic [3:0] SDiv    = 4'd6;
  localparam logic [3:0] SBpRd   = 4'd7;
  localparam logic [3:0] SBpNx   = 4'd8;
  localparam logic [3:0] SBpMul  = 4'd9;
  localparam logic [3:0] SBpMul2 = 4'd10;
  localparam logic [3:0] SBpWr   = 4'd11;
  localparam logic [3:0] SClose  = 4'd12;

  logic [3:0]      st_q, st_d;
  lmem_pkg::item_t it_q;
  logic [CntW-1:0] ecnt_q, ecnt_d;
  logic [CntW-1:0] k_q, k_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [AccW-1:0] recip_q;
  logic [55:0]     prod_q;
  logic [55:0]     phi_q, plo_q;
  logic [IdxW-1:0] bvox_q;
  logic [LenW-1:0] blen_q;

  // Memory ports.
  logic            cur_we, nxt_we, ev_we;
  logic [VAw-1:0]  cur_addr, nxt_addr;
  logic [EAw-1:0]  ev_addr;
  logic [ValW-1:0] cur_rd, nxt_rd, nxt_wd;
  logic [IdxW-1:0] evv_rd;
  logic [LenW-1:0] evl_rd;

  logic            div_start, div_done;
  logic [AccW-1:0] div_q_o;
  logic [AccW:0]   acc_sum;
  logic [56:0]     contrib_full;
  logic [ValW:0]   nsum;
  logic [ValW-1:0] contrib;

  lmem_ram #(.Width(ValW), .Depth(NumVoxels)) u_cur (
    .clk_i, .we_i(cur_we), .addr_i(cur_addr), .wdata_i(q_item_i.value), .rdata_o(cur_rd)
  );
  lmem_ram #(.Width(ValW), .Depth(NumVoxels)) u_nxt (
    .clk_i, .we_i(nxt_we), .addr_i(nxt_addr), .wdata_i(nxt_wd), .rdata_o(nxt_rd)
  );
  lmem_ram #(.Width(IdxW), .Depth(MaxElements)) u_evv (
    .clk_i, .we_i(ev_we), .addr_i(ev_addr), .wdata_i(it_q.idx), .rdata_o(evv_rd)
  );
  lmem_ram #(.Width(LenW), .Depth(MaxElements)) u_evl (
    .clk_i, .we_i(ev_we), .addr_i(ev_addr), .wdata_i(it_q.len), .rdata_o(evl_rd)
  );

  lmem_recip u_recip (
    .clk_i, .rst_ni, .start_i(div_start), .divisor_i(acc_q),
    .done_o(div_done), .recip_o(div_q_o)
  );

  // The 56-bit product shifted down by 16 leaves 40 significant bits.
  assign acc_sum      = {1'b0, acc_q} + {9'd0, prod_q[55:16]};
  assign contrib_full = {1'b0, phi_q} + {33'd0, plo_q[55:32]};
  assign contrib      = (contrib_full[56:32] != '0) ? {ValW{1'b1}} : contrib_full[31:0];
  assign nsum         = {1'b0, nxt_rd} + {1'b0, contrib};

  // Control sequencer.
  always_comb begin
    st_d      = st_q;
    ecnt_d    = ecnt_q;
    k_d       = k_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    q_pop_o   = 1'b0;
    cur_we    = 1'b0;
    nxt_we    = 1'b0;
    ev_we     = 1'b0;
    cur_addr  = q_item_i.idx[VAw-1:0];
    nxt_addr  = q_item_i.idx[VAw-1:0];
    nxt_wd    = q_item_i.value;
    ev_addr   = ecnt_q[EAw-1:0];
    div_start = 1'b0;
    case (st_q)
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            lmem_pkg::OpLoadCur:   cur_we = q_item_i.in_range;
            lmem_pkg::OpWriteNext: nxt_we = q_item_i.in_range;
            lmem_pkg::OpReadNext:  st_d = SRbRd;
            lmem_pkg::OpElement: begin
              if (q_item_i.in_range && ecnt_q < CntW'(MaxElements)) begin
                st_d = SElRd;
              end else begin
                if (q_item_i.in_range) ovf_d = 1'b1;
                st_d = q_item_i.last ? SClose : SIdle;
              end
            end
            default: st_d = SIdle;
          endcase
        end
      end
      SElRd: begin
        cur_addr = it_q.idx[VAw-1:0];
        ev_we    = 1'b1;
        st_d     = SElMul;
      end
      SElMul: st_d = SElAcc;
      SElAcc: begin
        acc_d  = acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
        ecnt_d = ecnt_q + CntW'(1);
        st_d   = it_q.last ? SClose : SIdle;
      end
      SRbRd: begin
        nxt_addr = it_q.idx[VAw-1:0];
        st_d     = SRbOut;
      end
      SRbOut: st_d = SIdle;
      SClose: begin
        k_d = '0;
        if (acc_q != '0) begin
          div_start = 1'b1;
          st_d      = SDiv;
        end else begin
          acc_d  = '0;
          ovf_d  = 1'b0;
          ecnt_d = '0;
          st_d   = SIdle;
        end
      end
      SDiv: begin
        if (div_done) st_d = (ecnt_q == '0) ? SIdle : SBpRd;
        if (div_done && ecnt_q == '0) begin
          acc_d = '0;
          ovf_d = 1'b0;
        end
      end
      SBpRd: begin
        ev_addr = k_q[EAw-1:0];
        st_d    = SBpNx;
      end
      SBpNx: begin
        nxt_addr = evv_rd[VAw-1:0];
        st_d     = SBpMul;
      end
      SBpMul: begin
        nxt_addr = bvox_q[VAw-1:0];
        st_d     = SBpMul2;
      end
      SBpMul2: begin
        nxt_addr = bvox_q[VAw-1:0];
        st_d     = SBpWr;
      end
      SBpWr: begin
        nxt_addr = bvox_q[VAw-1:0];
        nxt_we   = 1'b1;
        nxt_wd   = nsum[ValW] ? {ValW{1'b1}} : nsum[ValW-1:0];
        k_d      = k_q + CntW'(1);
        if (k_q + CntW'(1) == ecnt_q) begin
          acc_d  = '0;
          ovf_d  = 1'b0;
          ecnt_d = '0;
          st_d   = SIdle;
        end else begin
          st_d = SBpRd;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      ecnt_q <= '0;
      k_q    <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      ecnt_q <= ecnt_d;
      k_q    <= k_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
    end
  end

  // Datapath registers: products are registered before use.
  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && q_valid_i) it_q <= q_item_i;
    if (st_q == SElMul) prod_q <= cur_rd * it_q.len;
    if (st_q == SDiv && div_done) recip_q <= div_q_o;
    if (st_q == SBpNx) begin
      bvox_q <= evv_rd;
      blen_q <= evl_rd;
    end
    if (st_q == SBpMul) begin
      phi_q <= 56'(recip_q[AccW-1:32] * blen_q);
      plo_q <= recip_q[31:0] * blen_q;
    end
  end

  // Result strobe: readback or event close.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (st_q == SRbOut) || (st_q == SClose);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SRbOut) begin
      result_kind_o       <= lmem_pkg::KindReadback;
      result_value_o      <= it_q.in_range ? AccW'(nxt_rd) : '0;
      integral_positive_o <= 1'b0;
      element_overflow_o  <= 1'b0;
    end else if (st_q == SClose) begin
      result_kind_o       <= lmem_pkg::KindIntegral;
      result_value_o      <= acc_q;
      integral_positive_o <= (acc_q != '0);
      element_overflow_o  <= ovf_q;
    end
  end

  `ASSERT_CLK(a_ecnt_max, ecnt_q <= CntW'(MaxElements), "element count beyond depth")
  `ASSERT_CLK(a_pop_idle, q_pop_o |-> st_q == SIdle, "pop while working")
  `ASSERT_CLK(a_div_only_pos, div_start |-> acc_q != '0, "reciprocal of zero")
  `ASSERT_CLK(a_close_res, st_q == SClose |=> result_valid_o, "close without result")

endmodule
`default_nettype wire

[rtl/core/listmode_em_project_backproject_unit.sv]
//------------------------------------------------------------------------------
// listmode_em_project_backproject_unit
// List-mode EM forward projection and back projection engine.
//------------------------------------------------------------------------------
// Usage: drive an item on the operation and payload ports and raise start;
// it is taken at a clock edge where busy is low. A two-entry queue sits
// between the front part and the sequencer, so busy rises only when two
// items wait. Loads and writes of voxels give no result. A readback passes
// the states SRbRd and SRbOut, and its result strobe is registered from
// SRbOut. An event element goes through a current-image read, a registered
// multiply and the accumulate. The last element reports the integral; if it
// is positive, the reciprocal divider runs its 49 quotient steps and signals
// done, then each buffered element is scattered by an element read, a voxel
// read, two multiplies and a write. result_valid_o marks each result for
// one cycle; the receiver cannot stall, so results are never held. Reset
// clears the queue, the element count, the accumulator and the overflow
// flag; voxel memories keep undefined contents until written.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module listmode_em_project_backproject_unit #(
  parameter int unsigned NumVoxels   = lmem_pkg::NumVoxelsDefault,
  parameter int unsigned MaxElements = lmem_pkg::MaxElementsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                operation_i,
  input  wire logic [lmem_pkg::IdxW-1:0] voxel_index_i,
  input  wire logic [lmem_pkg::ValW-1:0] voxel_value_i,
  input  wire logic [lmem_pkg::LenW-1:0] path_length_i,
  input  wire logic                      last_element_i,
  output logic                           result_valid_o,
  output logic                           result_kind_o,
  output logic      [lmem_pkg::AccW-1:0] result_value_o,
  output logic                           integral_positive_o,
  output logic                           element_overflow_o
);

  logic            q_valid, q_pop;
  lmem_pkg::item_t q_item;

  lmem_front #(.NumVoxels(NumVoxels)) u_front (
    .clk_i, .rst_ni, .start_i(start), .operation_i, .voxel_index_i,
    .voxel_value_i, .path_length_i, .last_element_i, .busy_o(busy),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  lmem_back #(.NumVoxels(NumVoxels), .MaxElements(MaxElements)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .result_valid_o, .result_kind_o, .result_value_o, .integral_positive_o,
    .element_overflow_o
  );

endmodule
`default_nettype wire
